// ===== sv/alid_pkg.sv =====
package alid_pkg;

    // List geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the channels
    localparam int CMD_W = 3;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 6;

    // Common width for comparing a position against the element count
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ       = 3'd0,
        CMD_INS_BEFORE = 3'd1,
        CMD_INS_FIRST  = 3'd2,
        CMD_INS_LAST   = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_MODIFY     = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Operation broadcast to the row of cells
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    // Decoded command, from the controller to the datapath
    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   slot;
        logic               rd_en;
        status_t            status;
        logic [CNT_W-1:0]   count_next;
    } alid_op_t;

endpackage

// ===== sv/alid_if.sv =====
interface alid_cmd_if import alid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

interface alid_rsp_if import alid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        list_length;

    modport source (output valid, output read_value, output status, output list_length,
                    input ready);
    modport sink   (input valid, input read_value, input status, input list_length,
                    output ready);
endinterface

// ===== sv/alid_cell.sv =====
module alid_cell import alid_pkg::*; (
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [IDX_W-1:0] op_slot,
    input  logic [IDX_W-1:0] slot,
    input  logic [VAL_W-1:0] item_value,
    input  logic [VAL_W-1:0] prev_data,
    input  logic [VAL_W-1:0] next_data,
    output logic [VAL_W-1:0] data
);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             here;
    logic             above;

    // Locate this cell relative to the target slot
    assign here  = (slot == op_slot);
    assign above = (slot > op_slot);

    // Take the new value, a neighbor's value, or hold
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (here)
                    data_next = item_value;
                else if (above)
                    data_next = prev_data;
            end
            CELL_REMOVE:
            begin
                if (here || above)
                    data_next = next_data;
            end
            CELL_WRITE:
            begin
                if (here)
                    data_next = item_value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/alid_ctrl.sv =====
module alid_ctrl import alid_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [CMD_W-1:0] command,
    input  logic [POS_W-1:0] position,
    output alid_op_t         op,
    output logic [CNT_W-1:0] count
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    cmd_t             cmd;
    logic             full;
    logic             empty;
    logic             pos_ok;
    logic [POS_W-1:0] pos_dec;
    logic [IDX_W-1:0] pos_slot;
    logic [IDX_W-1:0] tail_slot;
    cell_op_t         cell_op;
    logic [IDX_W-1:0] slot;
    logic             rd_en;
    status_t          status;

    // List state checks
    assign cmd       = cmd_t'(command);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ok    = (position != '0) && (CMP_W'(position) <= CMP_W'(count_reg));
    assign pos_dec   = position - POS_W'(1);
    assign pos_slot  = IDX_W'(pos_dec);
    assign tail_slot = IDX_W'(count_reg);

    // Decode the command; full and empty take priority over position
    always_comb
    begin
        cell_op    = CELL_HOLD;
        slot       = pos_slot;
        rd_en      = 1'b0;
        status     = ST_OK;
        count_next = count_reg;
        case (cmd)
            CMD_READ:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (!pos_ok)
                    status = ST_BADPOS;
                else
                    rd_en = 1'b1;
            end
            CMD_INS_BEFORE:
            begin
                if (full)
                    status = ST_FULL;
                else if (!pos_ok)
                    status = ST_BADPOS;
                else
                begin
                    cell_op    = CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INS_FIRST:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cell_op    = CELL_INSERT;
                    slot       = '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INS_LAST:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cell_op    = CELL_WRITE;
                    slot       = tail_slot;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (!pos_ok)
                    status = ST_BADPOS;
                else
                begin
                    cell_op    = CELL_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_MODIFY:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (!pos_ok)
                    status = ST_BADPOS;
                else
                    cell_op = CELL_WRITE;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign op.op         = cell_op;
    assign op.slot       = slot;
    assign op.rd_en      = rd_en;
    assign op.status     = status;
    assign op.count_next = count_next;

    // Advance the element count on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    assign count = count_reg;

endmodule

// ===== sv/array_list_insert_delete_unit.sv =====
// Channel  Dir  Fields                                  Transaction
// -------  ---  --------------------------------------  -----------------------
// cmd      in   command, position, item_value           valid && ready
// rsp      out  read_value, status, list_length         valid && ready
//
// One command per cycle unless the response stalls: every cell updates in the
// accepting cycle, so a command follows its predecessor on the next clock with no gap.
// The response appears in the cycle after acceptance, in a single output register.
// cmd.ready drops only while a response is held and rsp.ready is low.
// Reset clears the element count and the response valid; cell contents are
// left as they are and only positions inside the list are ever read.
module array_list_insert_delete_unit import alid_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    alid_cmd_if.sink   cmd,
    alid_rsp_if.source rsp
);

    logic             accept;
    alid_op_t         op;
    logic [CNT_W-1:0] count;
    cell_op_t         cell_op;
    logic [VAL_W-1:0] cell_data [CAPACITY];
    logic [VAL_W-1:0] rd_word;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [VAL_W-1:0] read_value_reg;
    logic [ST_W-1:0]  status_reg;
    logic [LEN_W-1:0] len_reg;

    // Handshake: take a command whenever the response slot frees up
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    alid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (cmd.command),
        .position (cmd.position),
        .op       (op),
        .count    (count)
    );

    // Drive the row only on an accepted transaction
    assign cell_op = accept ? op.op : CELL_HOLD;

    // Row of entry cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VAL_W-1:0] prev_data;
        logic [VAL_W-1:0] next_data;

        if (g == 0)
        begin : g_first
            assign prev_data = '0;
        end
        else
        begin : g_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_next
            assign next_data = cell_data[g+1];
        end

        alid_cell u_cell (
            .clk        (clk),
            .op         (cell_op),
            .op_slot    (op.slot),
            .slot       (IDX_W'(g)),
            .item_value (cmd.item_value),
            .prev_data  (prev_data),
            .next_data  (next_data),
            .data       (cell_data[g])
        );
    end

    // Select the read word; zero unless a read succeeds
    assign rd_word = op.rd_en ? cell_data[op.slot] : '0;

    // Response valid
    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // Capture the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rd_word;
            status_reg     <= op.status;
            len_reg        <= LEN_W'(op.count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.status      = status_reg;
    assign rsp.list_length = len_reg;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // A successful shifting insert grows the list by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op.op == CELL_INSERT) |=> (count == $past(count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // A successful remove shrinks the list by one
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op.op == CELL_REMOVE) |=> (count == $past(count) - CNT_W'(1)))
        else $error("remove did not shrink the list");

    // An accepted transaction shows up with the updated length
    a_rsp_length: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.valid && rsp.list_length == LEN_W'(count)))
        else $error("response missing or length mismatch");

    // Error responses carry a zero read value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.read_value == '0))
        else $error("nonzero read value on error");

endmodule
